@@ design/html_entity_decoder_latin1_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the HTML entity decoder
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_DECODER_LATIN1_ASSERT_SVH
`define HTML_ENTITY_DECODER_LATIN1_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HED_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define HED_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HED_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define HED_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

@@ design/hed_pkg.sv @@
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, character codes and the entity name table.
// ----------------------------------------------------------------------------
package hed_pkg;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_SZLIG = 8'd223;

	localparam logic [2:0] REG_MODE_ADDR = 3'd0;

	typedef enum logic [2:0] {
		SEL_IN   = 3'd0,
		SEL_DEC  = 3'd1,
		SEL_AMP  = 3'd2,
		SEL_NAME = 3'd3,
		SEL_SEMI = 3'd4,
		SEL_END  = 3'd5
	} emit_sel_t;

	typedef struct packed {
		logic      take;
		logic      open;
		logic      close;
		logic      emit;
		emit_sel_t sel;
		logic      elast;
		logic      idx_clr;
		logic      idx_inc;
	} hed_cmd_t;

	typedef struct packed {
		logic coll;
		logic is_amp;
		logic is_semi;
		logic dec_ok;
		logic mode;
		logic len_zero;
		logic idx_last;
		logic out_free;
	} hed_stat_t;

	// hex digits of either case only when hex is set
	function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (hex && c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (hex && c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// key: length, then up to six characters right-justified; returns {hit, code}
	function automatic logic [8:0] name_lookup(input logic [50:0] key);
		logic [8:0] r;
		r = 9'd0;
		case (key)
			{3'd4, 48'("quot")}:   r = {1'b1, 8'd34};
			{3'd3, 48'("amp")}:    r = {1'b1, 8'd38};
			{3'd2, 48'("lt")}:     r = {1'b1, 8'd60};
			{3'd2, 48'("gt")}:     r = {1'b1, 8'd62};
			{3'd4, 48'("nbsp")}:   r = {1'b1, 8'd32};
			{3'd5, 48'("iexcl")}:  r = {1'b1, 8'd161};
			{3'd4, 48'("cent")}:   r = {1'b1, 8'd162};
			{3'd5, 48'("pound")}:  r = {1'b1, 8'd163};
			{3'd6, 48'("curren")}: r = {1'b1, 8'd164};
			{3'd3, 48'("yen")}:    r = {1'b1, 8'd165};
			{3'd6, 48'("brvbar")}: r = {1'b1, 8'd166};
			{3'd4, 48'("sect")}:   r = {1'b1, 8'd167};
			{3'd3, 48'("uml")}:    r = {1'b1, 8'd168};
			{3'd4, 48'("copy")}:   r = {1'b1, 8'd169};
			{3'd4, 48'("ordf")}:   r = {1'b1, 8'd170};
			{3'd5, 48'("laquo")}:  r = {1'b1, 8'd171};
			{3'd3, 48'("not")}:    r = {1'b1, 8'd172};
			{3'd3, 48'("shy")}:    r = {1'b1, 8'd173};
			{3'd3, 48'("reg")}:    r = {1'b1, 8'd174};
			{3'd4, 48'("macr")}:   r = {1'b1, 8'd175};
			{3'd3, 48'("deg")}:    r = {1'b1, 8'd176};
			{3'd6, 48'("plusmn")}: r = {1'b1, 8'd177};
			{3'd4, 48'("sup2")}:   r = {1'b1, 8'd178};
			{3'd4, 48'("sup3")}:   r = {1'b1, 8'd179};
			{3'd5, 48'("acute")}:  r = {1'b1, 8'd180};
			{3'd5, 48'("micro")}:  r = {1'b1, 8'd181};
			{3'd4, 48'("para")}:   r = {1'b1, 8'd182};
			{3'd6, 48'("middot")}: r = {1'b1, 8'd183};
			{3'd5, 48'("cedil")}:  r = {1'b1, 8'd184};
			{3'd4, 48'("sup1")}:   r = {1'b1, 8'd185};
			{3'd4, 48'("ordm")}:   r = {1'b1, 8'd186};
			{3'd5, 48'("raquo")}:  r = {1'b1, 8'd187};
			{3'd6, 48'("frac14")}: r = {1'b1, 8'd188};
			{3'd6, 48'("frac12")}: r = {1'b1, 8'd189};
			{3'd6, 48'("frac34")}: r = {1'b1, 8'd190};
			{3'd6, 48'("iquest")}: r = {1'b1, 8'd191};
			{3'd6, 48'("Agrave")}: r = {1'b1, 8'd192};
			{3'd6, 48'("Aacute")}: r = {1'b1, 8'd193};
			{3'd5, 48'("Acirc")}:  r = {1'b1, 8'd194};
			{3'd6, 48'("Atilde")}: r = {1'b1, 8'd195};
			{3'd4, 48'("Auml")}:   r = {1'b1, 8'd196};
			{3'd5, 48'("Aring")}:  r = {1'b1, 8'd197};
			{3'd5, 48'("AElig")}:  r = {1'b1, 8'd198};
			{3'd6, 48'("Ccedil")}: r = {1'b1, 8'd199};
			{3'd6, 48'("Egrave")}: r = {1'b1, 8'd200};
			{3'd6, 48'("Eacute")}: r = {1'b1, 8'd201};
			{3'd5, 48'("Ecirc")}:  r = {1'b1, 8'd202};
			{3'd4, 48'("Euml")}:   r = {1'b1, 8'd203};
			{3'd6, 48'("Igrave")}: r = {1'b1, 8'd204};
			{3'd6, 48'("Iacute")}: r = {1'b1, 8'd205};
			{3'd5, 48'("Icirc")}:  r = {1'b1, 8'd206};
			{3'd4, 48'("Iuml")}:   r = {1'b1, 8'd207};
			{3'd3, 48'("ETH")}:    r = {1'b1, 8'd208};
			{3'd6, 48'("Ntilde")}: r = {1'b1, 8'd209};
			{3'd6, 48'("Ograve")}: r = {1'b1, 8'd210};
			{3'd6, 48'("Oacute")}: r = {1'b1, 8'd211};
			{3'd5, 48'("Ocirc")}:  r = {1'b1, 8'd212};
			{3'd6, 48'("Otilde")}: r = {1'b1, 8'd213};
			{3'd4, 48'("Ouml")}:   r = {1'b1, 8'd214};
			{3'd5, 48'("times")}:  r = {1'b1, 8'd215};
			{3'd6, 48'("Oslash")}: r = {1'b1, 8'd216};
			{3'd6, 48'("Ugrave")}: r = {1'b1, 8'd217};
			{3'd6, 48'("Uacute")}: r = {1'b1, 8'd218};
			{3'd5, 48'("Ucirc")}:  r = {1'b1, 8'd219};
			{3'd4, 48'("Uuml")}:   r = {1'b1, 8'd220};
			{3'd6, 48'("Yacute")}: r = {1'b1, 8'd221};
			{3'd5, 48'("THORN")}:  r = {1'b1, 8'd222};
			{3'd5, 48'("szlig")}:  r = {1'b1, 8'd223};
			{3'd4, 48'("beta")}:   r = {1'b1, 8'd223};
			{3'd6, 48'("agrave")}: r = {1'b1, 8'd224};
			{3'd6, 48'("aacute")}: r = {1'b1, 8'd225};
			{3'd5, 48'("acirc")}:  r = {1'b1, 8'd226};
			{3'd6, 48'("atilde")}: r = {1'b1, 8'd227};
			{3'd4, 48'("auml")}:   r = {1'b1, 8'd228};
			{3'd5, 48'("aring")}:  r = {1'b1, 8'd229};
			{3'd5, 48'("aelig")}:  r = {1'b1, 8'd230};
			{3'd6, 48'("ccedil")}: r = {1'b1, 8'd231};
			{3'd6, 48'("egrave")}: r = {1'b1, 8'd232};
			{3'd6, 48'("eacute")}: r = {1'b1, 8'd233};
			{3'd5, 48'("ecirc")}:  r = {1'b1, 8'd234};
			{3'd4, 48'("euml")}:   r = {1'b1, 8'd235};
			{3'd6, 48'("igrave")}: r = {1'b1, 8'd236};
			{3'd6, 48'("iacute")}: r = {1'b1, 8'd237};
			{3'd5, 48'("icirc")}:  r = {1'b1, 8'd238};
			{3'd4, 48'("iuml")}:   r = {1'b1, 8'd239};
			{3'd3, 48'("eth")}:    r = {1'b1, 8'd240};
			{3'd6, 48'("ntilde")}: r = {1'b1, 8'd241};
			{3'd6, 48'("ograve")}: r = {1'b1, 8'd242};
			{3'd6, 48'("oacute")}: r = {1'b1, 8'd243};
			{3'd5, 48'("ocirc")}:  r = {1'b1, 8'd244};
			{3'd6, 48'("otilde")}: r = {1'b1, 8'd245};
			{3'd4, 48'("ouml")}:   r = {1'b1, 8'd246};
			{3'd6, 48'("divide")}: r = {1'b1, 8'd247};
			{3'd6, 48'("oslash")}: r = {1'b1, 8'd248};
			{3'd6, 48'("ugrave")}: r = {1'b1, 8'd249};
			{3'd6, 48'("uacute")}: r = {1'b1, 8'd250};
			{3'd5, 48'("ucirc")}:  r = {1'b1, 8'd251};
			{3'd4, 48'("uuml")}:   r = {1'b1, 8'd252};
			{3'd6, 48'("yacute")}: r = {1'b1, 8'd253};
			{3'd5, 48'("thorn")}:  r = {1'b1, 8'd254};
			{3'd4, 48'("yuml")}:   r = {1'b1, 8'd255};
			default:               r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

@@ design/hed_dp.sv @@
// ----------------------------------------------------------------------------
// hed_dp
// Name buffer, running numeric decode, name lookup, output register, mode reg.
// ----------------------------------------------------------------------------
`include "html_entity_decoder_latin1_assert.svh"

module hed_dp #(
	parameter int MAX_NAME_LEN = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hed_pkg::hed_cmd_t cmd,
	output hed_pkg::hed_stat_t stat,
	input  logic [7:0]       in_byte,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [7:0]       out_byte,
	output logic             out_valid,
	output logic             out_last,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata
);
	import hed_pkg::*;

	localparam int LEN_W = $clog2(MAX_NAME_LEN + 1);
	localparam int IDX_W = $clog2(MAX_NAME_LEN);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_NAME_LEN);

	logic             mode_q;
	logic             coll_q;
	logic [7:0]       name_q [MAX_NAME_LEN];
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic [IDX_W-1:0] idx_q;
	// running numeric reference
	logic             hash_q, hex_q, stop_q, ndig_q;
	logic [16:0]      val_q;

	logic             res_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_valid_q, out_last_q;

	logic             is_amp, is_semi, out_free, store_en, num_en;
	logic [4:0]       dig;
	logic [21:0]      acc;
	logic [47:0]      key;
	logic [8:0]       hit;
	logic             num_ok, name_ok;
	logic [7:0]       dec_byte, emit_byte;

	assign is_amp   = (in_byte == CH_AMP);
	assign is_semi  = (in_byte == CH_SEMI);
	assign out_free = !res_valid_q || !res_stall;
	assign store_en = cmd.take && coll_q && !is_amp && !is_semi;

	// a digit is taken from position 1 on, except the 'x' that selects hex
	assign dig    = digit_val(in_byte, hex_q);
	assign num_en = store_en && (len_q < LEN_MAX) && hash_q && !stop_q && (len_q != '0)
		&& !(len_q == LEN_W'(1) && in_byte == CH_X);
	assign acc = (hex_q ? {1'b0, val_q, 4'b0} : ({2'b0, val_q, 3'b0} + {4'b0, val_q, 1'b0}))
		+ {18'b0, dig[3:0]};

	always_comb begin
		key = '0;
		for (int i = 0; i < 6; i++) begin
			if (LEN_W'(i) < len_q)
				key = {key[39:0], name_q[i]};
		end
	end
	assign hit = (len_q <= LEN_W'(6)) ? name_lookup({3'(len_q), key}) : 9'd0;

	assign num_ok = hash_q && ndig_q
		&& (val_q <= 17'd255 || val_q == 17'd946 || val_q == 17'h0CF90);
	assign name_ok = !hash_q && hit[8];
	assign dec_byte = hash_q ? ((val_q <= 17'd255) ? val_q[7:0] : CH_SZLIG) : hit[7:0];

	always_comb begin
		stat.coll     = coll_q;
		stat.is_amp   = is_amp;
		stat.is_semi  = is_semi;
		stat.dec_ok   = !ovf_q && (len_q != '0) && (num_ok || name_ok);
		stat.mode     = mode_q;
		stat.len_zero = (len_q == '0);
		stat.idx_last = (LEN_W'(idx_q) + LEN_W'(1) == len_q);
		stat.out_free = out_free;
	end

	always_comb begin
		case (cmd.sel)
			SEL_IN:   emit_byte = in_byte;
			SEL_DEC:  emit_byte = dec_byte;
			SEL_AMP:  emit_byte = CH_AMP;
			SEL_NAME: emit_byte = name_q[idx_q];
			SEL_SEMI: emit_byte = CH_SEMI;
			SEL_END:  emit_byte = 8'd0;
			default:  emit_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == REG_MODE_ADDR) begin
			mode_q <= pwdata[0];
		end
	end
	assign prdata = (paddr == REG_MODE_ADDR) ? {31'b0, mode_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coll_q <= 1'b0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			hash_q <= 1'b0;
			hex_q  <= 1'b0;
			stop_q <= 1'b0;
			ndig_q <= 1'b0;
			val_q  <= '0;
			idx_q  <= '0;
		end else begin
			if ((cmd.take && !coll_q && is_amp) || cmd.open) begin
				coll_q <= 1'b1;
				len_q  <= '0;
				ovf_q  <= 1'b0;
				hash_q <= 1'b0;
				hex_q  <= 1'b0;
				stop_q <= 1'b0;
				ndig_q <= 1'b0;
				val_q  <= '0;
			end else if (cmd.close) begin
				coll_q <= 1'b0;
			end else if (store_en) begin
				if (len_q < LEN_MAX) begin
					len_q <= len_q + LEN_W'(1);
					if (len_q == '0)
						hash_q <= (in_byte == CH_HASH);
					if (hash_q && len_q == LEN_W'(1) && in_byte == CH_X)
						hex_q <= 1'b1;
					if (num_en) begin
						if (!dig[4]) begin
							stop_q <= 1'b1;
						end else begin
							ndig_q <= 1'b1;
							val_q  <= (acc > 22'h00FFFF) ? 17'h10000 : acc[16:0];
						end
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (store_en && len_q < LEN_MAX)
			name_q[len_q[IDX_W-1:0]] <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q  <= emit_byte;
			out_valid_q <= (cmd.sel != SEL_END);
			out_last_q  <= cmd.elast;
		end
	end

	assign res_valid = res_valid_q;
	assign out_byte  = out_byte_q;
	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;

	`HED_ASSERT_IMP(a_len_bound, clk, arst_n, 1'b1, len_q <= LEN_MAX, "name length overran")
	`HED_ASSERT_IMP(a_ovf_full, clk, arst_n, ovf_q, len_q == LEN_MAX, "overflow below full")
	`HED_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit, out_free, "emit into a held result")

endmodule

@@ design/hed_ctrl.sv @@
// ----------------------------------------------------------------------------
// hed_ctrl
// Sequencer: accepts bytes, walks the entity finish and re-emit sequence.
// ----------------------------------------------------------------------------
`include "html_entity_decoder_latin1_assert.svh"

module hed_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               in_last,
	input  hed_pkg::hed_stat_t stat,
	output hed_pkg::hed_cmd_t  cmd
);
	import hed_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_FIN  = 7'b0000010,
		S_NAME = 7'b0000100,
		S_SEMI = 7'b0001000,
		S_POST = 7'b0010000,
		S_END  = 7'b0100000,
		S_SPARE = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   last_q, atend_q, final_q, reopen_q, emitted_q;
	logic   last_d, atend_d, final_d, reopen_d, emitted_d;
	logic   accept;

	assign in_stall = !(state_q == S_IDLE && stat.out_free);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d   = state_q;
		last_d    = last_q;
		atend_d   = atend_q;
		final_d   = final_q;
		reopen_d  = reopen_q;
		emitted_d = emitted_q;
		cmd       = '0;
		cmd.sel   = SEL_IN;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.take  = 1'b1;
					last_d    = in_last;
					emitted_d = 1'b0;
					atend_d   = 1'b0;
					final_d   = in_last;
					reopen_d  = 1'b0;
					if (!stat.coll) begin
						if (!stat.is_amp) begin
							cmd.emit  = 1'b1;
							cmd.elast = in_last;
						end else if (in_last) begin
							atend_d = 1'b1;
							state_d = S_FIN;
						end
					end else if (stat.is_semi) begin
						state_d = S_FIN;
					end else if (stat.is_amp) begin
						// in pass-through a trailing lone ampersand still follows
						final_d  = in_last && !stat.mode;
						reopen_d = 1'b1;
						state_d  = S_FIN;
					end else if (in_last) begin
						atend_d = 1'b1;
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				cmd.idx_clr = 1'b1;
				if (stat.dec_ok) begin
					if (stat.out_free) begin
						cmd.emit  = 1'b1;
						cmd.sel   = SEL_DEC;
						cmd.elast = final_q;
						emitted_d = 1'b1;
						state_d   = S_POST;
					end
				end else if (!stat.mode) begin
					state_d = S_POST;
				end else if (stat.out_free) begin
					cmd.emit  = 1'b1;
					cmd.sel   = SEL_AMP;
					cmd.elast = final_q && atend_q && stat.len_zero;
					emitted_d = 1'b1;
					if (atend_q && stat.len_zero)
						state_d = S_POST;
					else if (stat.len_zero)
						state_d = S_SEMI;
					else
						state_d = S_NAME;
				end
			end
			S_NAME: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_NAME;
					if (stat.idx_last)
						state_d = S_SEMI;
					else
						cmd.idx_inc = 1'b1;
				end
			end
			S_SEMI: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					cmd.sel   = SEL_SEMI;
					cmd.elast = final_q;
					state_d   = S_POST;
				end
			end
			S_POST: begin
				if (reopen_q) begin
					cmd.open = 1'b1;
					reopen_d = 1'b0;
					if (last_q) begin
						atend_d = 1'b1;
						final_d = 1'b1;
						state_d = S_FIN;
					end else begin
						state_d = S_IDLE;
					end
				end else begin
					cmd.close = 1'b1;
					state_d   = (last_q && !emitted_q) ? S_END : S_IDLE;
				end
			end
			S_END: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					cmd.sel   = SEL_END;
					cmd.elast = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			last_q    <= 1'b0;
			atend_q   <= 1'b0;
			final_q   <= 1'b0;
			reopen_q  <= 1'b0;
			emitted_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			last_q    <= last_d;
			atend_q   <= atend_d;
			final_q   <= final_d;
			reopen_q  <= reopen_d;
			emitted_q <= emitted_d;
		end
	end

	`HED_ASSERT_NXT(a_bare_end, clk, arst_n,
		state_q == S_POST && !reopen_q && last_q && !emitted_q, state_q == S_END,
		"missing end marker")
	`HED_ASSERT_IMP(a_take_idle, clk, arst_n, cmd.take, state_q == S_IDLE && in_valid,
		"byte taken outside idle")
	`HED_ASSERT_IMP(a_last_mark, clk, arst_n, cmd.emit && cmd.elast && state_q != S_IDLE,
		last_q, "end flag on a non-final transaction")

endmodule

@@ design/html_entity_decoder_latin1.sv @@
// ----------------------------------------------------------------------------
// html_entity_decoder_latin1
// HTML character entity decoder with Latin-1 output.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries in_byte and in_last; the result
// channel res_valid/res_stall carries out_byte, out_valid and out_last.
// Plain text bytes leave the result register in the cycle after acceptance.
// Entity text is buffered a byte per cycle while the input is not stalled; after
// the closing ';', '&' or end of text the sequencer emits any result bytes in
// turn (the first step also decides) and then takes a wrap-up step; a second
// ampersand at end of text adds one pass more.
// The single result register sets the pace: at most one byte leaves per cycle.
// A result stalled by res_stall holds and the block stalls its input.
// Register 0 (APB address 0) bit 0: 0 drops unknown entities, 1 re-emits them.
// Reset clears the mode, the entity state and res_valid; the name buffer and the
// result byte and flags are not cleared. A final byte that yields nothing gives a
// bare marker with out_valid 0 and out_last 1.
// ----------------------------------------------------------------------------
module html_entity_decoder_latin1 #(
	parameter int MAX_NAME_LEN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        out_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hed_pkg::*;

	hed_cmd_t  cmd;
	hed_stat_t stat;

	assign pready = 1'b1;

	hed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_last  (in_last),
		.stat     (stat),
		.cmd      (cmd)
	);

	hed_dp #(
		.MAX_NAME_LEN (MAX_NAME_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_byte   (in_byte),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_byte  (out_byte),
		.out_valid (out_valid),
		.out_last  (out_last),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata)
	);

endmodule

@@ tb/hed_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hed_checker
// Watches both channels of the entity decoder, predicts the Latin-1 output
// stream from the accepted input bytes and compares it field by field.
// ----------------------------------------------------------------------------
module hed_checker #(
	parameter int MAX_NAME_LEN = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       res_valid,
	input  logic       res_stall,
	input  logic [7:0] out_byte,
	input  logic       out_valid,
	input  logic       out_last,
	input  logic       mode,
	output int         fail_count,
	output int         pending
);
	import hed_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		logic       v;
		logic       l;
	} out_item_t;

	out_item_t  expected_bytes[$];
	logic       in_entity;
	logic [7:0] name_buf[MAX_NAME_LEN];
	int         name_len;
	logic       name_ovf;

	assign pending = expected_bytes.size();

	function automatic logic [8:0] named_code(input string s);
		case (s)
			"quot": return {1'b1, 8'd34};    "amp": return {1'b1, 8'd38};
			"lt": return {1'b1, 8'd60};      "gt": return {1'b1, 8'd62};
			"nbsp": return {1'b1, 8'd32};    "iexcl": return {1'b1, 8'd161};
			"cent": return {1'b1, 8'd162};   "pound": return {1'b1, 8'd163};
			"curren": return {1'b1, 8'd164}; "yen": return {1'b1, 8'd165};
			"brvbar": return {1'b1, 8'd166}; "sect": return {1'b1, 8'd167};
			"uml": return {1'b1, 8'd168};    "copy": return {1'b1, 8'd169};
			"ordf": return {1'b1, 8'd170};   "laquo": return {1'b1, 8'd171};
			"not": return {1'b1, 8'd172};    "shy": return {1'b1, 8'd173};
			"reg": return {1'b1, 8'd174};    "macr": return {1'b1, 8'd175};
			"deg": return {1'b1, 8'd176};    "plusmn": return {1'b1, 8'd177};
			"sup2": return {1'b1, 8'd178};   "sup3": return {1'b1, 8'd179};
			"acute": return {1'b1, 8'd180};  "micro": return {1'b1, 8'd181};
			"para": return {1'b1, 8'd182};   "middot": return {1'b1, 8'd183};
			"cedil": return {1'b1, 8'd184};  "sup1": return {1'b1, 8'd185};
			"ordm": return {1'b1, 8'd186};   "raquo": return {1'b1, 8'd187};
			"frac14": return {1'b1, 8'd188}; "frac12": return {1'b1, 8'd189};
			"frac34": return {1'b1, 8'd190}; "iquest": return {1'b1, 8'd191};
			"Agrave": return {1'b1, 8'd192}; "Aacute": return {1'b1, 8'd193};
			"Acirc": return {1'b1, 8'd194};  "Atilde": return {1'b1, 8'd195};
			"Auml": return {1'b1, 8'd196};   "Aring": return {1'b1, 8'd197};
			"AElig": return {1'b1, 8'd198};  "Ccedil": return {1'b1, 8'd199};
			"Egrave": return {1'b1, 8'd200}; "Eacute": return {1'b1, 8'd201};
			"Ecirc": return {1'b1, 8'd202};  "Euml": return {1'b1, 8'd203};
			"Igrave": return {1'b1, 8'd204}; "Iacute": return {1'b1, 8'd205};
			"Icirc": return {1'b1, 8'd206};  "Iuml": return {1'b1, 8'd207};
			"ETH": return {1'b1, 8'd208};    "Ntilde": return {1'b1, 8'd209};
			"Ograve": return {1'b1, 8'd210}; "Oacute": return {1'b1, 8'd211};
			"Ocirc": return {1'b1, 8'd212};  "Otilde": return {1'b1, 8'd213};
			"Ouml": return {1'b1, 8'd214};   "times": return {1'b1, 8'd215};
			"Oslash": return {1'b1, 8'd216}; "Ugrave": return {1'b1, 8'd217};
			"Uacute": return {1'b1, 8'd218}; "Ucirc": return {1'b1, 8'd219};
			"Uuml": return {1'b1, 8'd220};   "Yacute": return {1'b1, 8'd221};
			"THORN": return {1'b1, 8'd222};  "szlig": return {1'b1, 8'd223};
			"beta": return {1'b1, 8'd223};   "agrave": return {1'b1, 8'd224};
			"aacute": return {1'b1, 8'd225}; "acirc": return {1'b1, 8'd226};
			"atilde": return {1'b1, 8'd227}; "auml": return {1'b1, 8'd228};
			"aring": return {1'b1, 8'd229};  "aelig": return {1'b1, 8'd230};
			"ccedil": return {1'b1, 8'd231}; "egrave": return {1'b1, 8'd232};
			"eacute": return {1'b1, 8'd233}; "ecirc": return {1'b1, 8'd234};
			"euml": return {1'b1, 8'd235};   "igrave": return {1'b1, 8'd236};
			"iacute": return {1'b1, 8'd237}; "icirc": return {1'b1, 8'd238};
			"iuml": return {1'b1, 8'd239};   "eth": return {1'b1, 8'd240};
			"ntilde": return {1'b1, 8'd241}; "ograve": return {1'b1, 8'd242};
			"oacute": return {1'b1, 8'd243}; "ocirc": return {1'b1, 8'd244};
			"otilde": return {1'b1, 8'd245}; "ouml": return {1'b1, 8'd246};
			"divide": return {1'b1, 8'd247}; "oslash": return {1'b1, 8'd248};
			"ugrave": return {1'b1, 8'd249}; "uacute": return {1'b1, 8'd250};
			"ucirc": return {1'b1, 8'd251};  "uuml": return {1'b1, 8'd252};
			"yacute": return {1'b1, 8'd253}; "thorn": return {1'b1, 8'd254};
			"yuml": return {1'b1, 8'd255};
			default: return 9'd0;
		endcase
	endfunction

	// {hit, byte} for the buffered name
	function automatic logic [8:0] resolve_name();
		string s;
		logic  hex;
		int    v, d, ndig, i;
		logic [7:0] c;
		s = "";
		v = 0;
		ndig = 0;
		if (name_ovf || name_len == 0)
			return 9'd0;
		if (name_buf[0] == CH_HASH) begin
			hex = (name_len >= 2 && name_buf[1] == CH_X);
			for (i = hex ? 2 : 1; i < name_len; i++) begin
				c = name_buf[i];
				if (c >= "0" && c <= "9") d = c - "0";
				else if (hex && c >= "a" && c <= "f") d = c - "a" + 10;
				else if (hex && c >= "A" && c <= "F") d = c - "A" + 10;
				else break;
				v = v * (hex ? 16 : 10) + d;
				if (v > 'hFFFF) v = 'h10000;
				ndig++;
			end
			if (ndig == 0) return 9'd0;
			if (v <= 255) return {1'b1, 8'(v)};
			if (v == 946 || v == 'hCF90) return {1'b1, CH_SZLIG};
			return 9'd0;
		end
		// a zero byte can never match a table name
		for (i = 0; i < name_len; i++) begin
			if (name_buf[i] == 8'd0) return 9'd0;
			s = {s, string'(name_buf[i])};
		end
		return named_code(s);
	endfunction

	task automatic close_entity(input logic at_end, inout int n);
		logic [8:0] r;
		r = resolve_name();
		if (r[8]) begin
			expected_bytes.push_back('{r[7:0], 1'b1, 1'b0});
			n++;
		end else if (mode) begin
			expected_bytes.push_back('{CH_AMP, 1'b1, 1'b0});
			n++;
			if (!(at_end && name_len == 0)) begin
				for (int i = 0; i < name_len; i++)
					expected_bytes.push_back('{name_buf[i], 1'b1, 1'b0});
				expected_bytes.push_back('{CH_SEMI, 1'b1, 1'b0});
				n += name_len + 1;
			end
		end
	endtask

	task automatic decode_byte(input logic [7:0] c, input logic lst);
		int n;
		n = 0;
		if (!in_entity) begin
			if (c == CH_AMP) begin
				in_entity = 1'b1; name_len = 0; name_ovf = 1'b0;
			end else begin
				expected_bytes.push_back('{c, 1'b1, 1'b0});
				n++;
			end
		end else if (c == CH_SEMI) begin
			close_entity(1'b0, n);
			in_entity = 1'b0;
		end else if (c == CH_AMP) begin
			close_entity(1'b0, n);
			name_len = 0; name_ovf = 1'b0;
		end else if (name_len < MAX_NAME_LEN) begin
			name_buf[name_len] = c;
			name_len++;
		end else
			name_ovf = 1'b1;
		if (lst) begin
			if (in_entity) begin
				close_entity(1'b1, n);
				in_entity = 1'b0;
			end
			if (n == 0)
				expected_bytes.push_back('{8'd0, 1'b0, 1'b1});
			else
				expected_bytes[$].l = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			in_entity = 1'b0;
			name_len = 0;
			name_ovf = 1'b0;
			fail_count = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected result byte %0h", out_byte);
					fail_count++;
				end else begin
					e = expected_bytes.pop_front();
					if (out_byte !== e.b) begin
						$error("out_byte expected %0h actual %0h", e.b, out_byte);
						fail_count++;
					end
					if (out_valid !== e.v) begin
						$error("out_valid expected %0b actual %0b", e.v, out_valid);
						fail_count++;
					end
					if (out_last !== e.l) begin
						$error("out_last expected %0b actual %0b", e.l, out_last);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				decode_byte(in_byte, in_last);
		end
	end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives entity-laden text into the decoder under random bursts and stalls,
// switching the unknown-entity mode between phases; verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
	import hed_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'd0;
	logic        in_last = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        out_valid;
	logic        out_last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        mode_shadow = 1'b0;
	int          fail_count;
	int          pending;
	logic        hold_off = 1'b0;

	always #6 clk = ~clk;

	html_entity_decoder_latin1 DUT (.*);

	hed_checker CHK (
		.clk, .arst_n, .in_valid, .in_stall, .in_byte, .in_last, .res_valid,
		.res_stall, .out_byte, .out_valid, .out_last, .mode(mode_shadow),
		.fail_count, .pending
	);

	// receiver stall pattern, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_off)
			res_stall <= 1'b1;
		else case ($urandom_range(0, 3))
			0: res_stall <= ($urandom_range(0, 1) == 0);
			1: res_stall <= ($urandom_range(0, 4) == 0);
			default: res_stall <= 1'b0;
		endcase
	end

	task automatic write_mode(input logic m);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_MODE_ADDR; pwdata <= {31'd0, m};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		mode_shadow <= m;
	endtask

	int burst_left = 0;

	task automatic send(input logic [7:0] b, input logic lst);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1'b1; in_byte <= b; in_last <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		if (burst_left == 0) in_valid <= 1'b0;
	endtask

	task automatic send_text(input string s, input logic lst);
		for (int i = 0; i < s.len(); i++)
			send(s[i], lst && i == s.len() - 1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic string rand_entity();
		string names[12] = '{"amp", "lt", "nbsp", "frac14", "frac34", "szlig",
			"yuml", "Agrave", "beta", "frac12", "bogus", "ETH"};
		string s;
		int k;
		k = $urandom_range(0, 7);
		case (k)
			0: s = $sformatf("#%0d", $urandom_range(0, 300));
			1: s = $sformatf("#x%0h", $urandom_range(0, 300));
			2: s = $sformatf("#X%0h", $urandom_range(0, 20));
			3: s = ($urandom_range(0, 1) != 0) ? "#946" : "#xCF90";
			4: begin
				s = "";
				repeat ($urandom_range(0, 20)) s = {s, string'(8'($urandom_range(33, 126)))};
			end
			default: s = names[$urandom_range(0, 11)];
		endcase
		return {"&", s, ($urandom_range(0, 5) == 0) ? "" : ";"};
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		write_mode(1'b0);
		// directed
		send_text("a&amp;&lt&gt;&#65;&#x41;&#946;&#xCF90;&#xzz;&frac14;", 1'b0);
		send(8'hFF, 1'b0); send(8'h00, 1'b1);
		send_text("&", 1'b1);
		drain();
		write_mode(1'b1);
		send_text("&nbsp;&abcdefghijklmnopqrs;&#99999;&bad&", 1'b1);
		send_text("&#;&x", 1'b1);
		send(CH_AMP, 1'b0); send(8'h00, 1'b0); send(CH_SEMI, 1'b1);
		drain();
		// random phases with alternating mode
		for (int ph = 0; ph < 4; ph++) begin
			write_mode(ph[0]);
			for (int t = 0; t < 5; t++) begin
				if (ph == 2 && t == 3) hold_off <= 1'b1;
				if ($urandom_range(0, 4) == 0)
					send(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
				else
					send_text({rand_entity(), "x"}, $urandom_range(0, 3) == 0);
			end
			send_text("z", 1'b1);
			drain();
		end
		if (fail_count == 0)
			$display("html_entity_decoder_latin1 test passed");
		else
			$display("html_entity_decoder_latin1 test failed");
		$finish;
	end

	// long stall from the receiver: counted cycles while sender keeps offering
	initial begin
		wait (hold_off);
		repeat (60) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5ms;
		$display("html_entity_decoder_latin1 test failed");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+design
design/hed_pkg.sv
design/hed_dp.sv
design/hed_ctrl.sv
design/html_entity_decoder_latin1.sv
tb/hed_checker.sv
tb/tb_top.sv
